### rtl/ccd_pkg.sv
// Types, constants and calendar arithmetic for the calendar clock with summer time.
`default_nettype none

package ccd_pkg;

  // Command codes
  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdLoad    = 2'd1;
  localparam logic [1:0] CmdLoadDst = 2'd2;

  // Weekday: floor(y / 100) as (y * YearRecip) >> YearShift, exact for y below 43000
  localparam int unsigned YearBias  = 400;
  localparam int unsigned YearRecip = 5243;
  localparam int unsigned YearShift = 19;

  localparam logic [2:0] MonthOffset [12] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
  };

  // One command item as it travels down the pipe
  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } load_t;

  // Clock and calendar state
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  wday;
    logic        rep;
  } clock_t;

  localparam clock_t ClockReset = '{
    second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1,
    year: 12'd2023, wday: 3'd0, rep: 1'b0
  };

  // Remainder by 7 of a 14-bit value: 8 is 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [13:0] v);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[13:12]);
    f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
    return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  endfunction

  // Hour increment with day, month and year carry
  function automatic clock_t add_one_hour(input clock_t st);
    clock_t     r;
    logic [5:0] nd;
    logic [4:0] nm;
    r  = st;
    nd = 6'(st.day) + 6'd1;
    nm = 5'(st.month);
    if (st.hour >= 5'd23) begin
      r.hour = 5'd0;
      r.wday = (st.wday >= 3'd6) ? 3'd0 : st.wday + 3'd1;
      if (nd >= 6'd32) begin
        nd = 6'd1;
        nm = nm + 5'd1;
      end
      if (nd == 6'd31 && (nm == 5'd4 || nm == 5'd6 || nm == 5'd9 || nm == 5'd11)) begin
        nd = 6'd1;
        nm = nm + 5'd1;
      end
      if (nd == 6'd30 && nm == 5'd2) begin
        nd = 6'd1;
        nm = nm + 5'd1;
      end
      if (nd == 6'd29 && nm == 5'd2 && st.year[1:0] != 2'd0) begin
        nd = 6'd1;
        nm = nm + 5'd1;
      end
      if (nm >= 5'd13) begin
        nm     = 5'd1;
        r.year = st.year + 12'd1;
      end
      r.day   = nd[4:0];
      r.month = nm[3:0];
    end else begin
      r.hour = st.hour + 5'd1;
    end
    return r;
  endfunction

  // One second forward, with the spring and autumn hour switches
  function automatic clock_t tick_second(input clock_t st);
    clock_t r;
    r = st;
    if (st.second < 6'd59) begin
      r.second = st.second + 6'd1;
    end else begin
      r.second = 6'd0;
      if (st.minute < 6'd59) begin
        r.minute = st.minute + 6'd1;
      end else begin
        r.minute = 6'd0;
        if (st.day > 5'd24 && st.wday == 3'd0) begin
          if (st.month == 4'd3 && st.hour == 5'd1) begin
            r.hour = 5'd2;
          end else if (st.month == 4'd10 && st.hour == 5'd2) begin
            if (!st.rep) r.hour = 5'd1;
            r.rep = ~st.rep;
          end
        end
        r = add_one_hour(r);
      end
    end
    return r;
  endfunction

  // True when a winter-time value lies in the summer-time period
  function automatic logic is_summer(input clock_t st);
    logic last_week;
    logic past_sunday;
    logic summer;
    last_week   = st.day > 5'd24;
    past_sunday = last_week && (5'(st.wday) <= st.day - 5'd25);
    summer      = 1'b0;
    if (st.month == 4'd3 && last_week) begin
      summer = past_sunday;
      if (st.wday == 3'd0 && st.hour < 5'd2) summer = 1'b0;
    end else if (st.month >= 4'd4 && st.month <= 4'd10) begin
      summer = 1'b1;
      if (st.month == 4'd10 && last_week) begin
        if (past_sunday) summer = 1'b0;
        if (st.wday == 3'd0 && st.hour < 5'd3) summer = 1'b1;
      end
    end
    return summer;
  endfunction

endpackage

`default_nettype wire

### rtl/ccd_cmd_if.sv
// Command channel: valid/ready handshake with one command item.
`default_nettype none

interface ccd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [4:0]  load_hour;
  logic [5:0]  load_minute;
  logic [5:0]  load_second;

  modport source (
    output valid, command, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    input  ready
  );
  modport sink (
    input  valid, command, load_year, load_month, load_day, load_hour,
           load_minute, load_second,
    output ready
  );
endinterface

`default_nettype wire

### rtl/ccd_status_if.sv
// Status channel: valid/ready handshake with one clock reading item.
`default_nettype none

interface ccd_status_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cur_second;
  logic [5:0]  cur_minute;
  logic [4:0]  cur_hour;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [11:0] cur_year;
  logic [2:0]  cur_weekday;
  logic        summer_applied;

  modport source (
    output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, cur_weekday, summer_applied,
    input  ready
  );
  modport sink (
    input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
           cur_year, cur_weekday, summer_applied,
    output ready
  );
endinterface

`default_nettype wire

### rtl/calendar_clock_with_dst_top.sv
// Calendar clock, 2000..2099, with Central European summer-time switches.
//
// Channels: cmd takes one item per command (tick one second, load, or load
// winter time with summer correction); status returns one item per command
// carrying the clock after that command. Both use valid/ready.
// Pipe: a command passes three registered stages (weekday multiply, weekday
// remainder, state update). Throughput: one command per cycle unless status
// stalls; the clock state register is updated once per item in the last
// stage, so ticks may follow loads back to back.
// Reset (rst, synchronous): clock goes to 2023-01-01 00:00:00, Sunday,
// repeat-hour flag clear; the pipe is emptied.
// Stall: the status register holds its item while ready is low; the two
// upstream stages keep filling, and cmd.ready drops only when all three
// stages hold items and status is not taken.
`default_nettype none

module calendar_clock_with_dst_top (
  input  wire logic     clk,
  input  wire logic     rst,
  ccd_cmd_if.sink       cmd,
  ccd_status_if.source  status
);

  // Pipe control
  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic adv3;

  assign rdy3 = !out_valid || status.ready;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign adv3 = s2_valid && rdy3;
  assign cmd.ready = rdy1;

  // Front: biased year and century from the incoming item
  ccd_pkg::load_t in_load;
  logic [12:0]    in_y;
  logic [25:0]    in_prod;
  logic [3:0]     in_idx;

  assign in_load = '{
    command: cmd.command, year: cmd.load_year, month: cmd.load_month,
    day: cmd.load_day, hour: cmd.load_hour, minute: cmd.load_minute,
    second: cmd.load_second
  };
  assign in_y = 13'(cmd.load_year) + 13'(ccd_pkg::YearBias)
              - ((cmd.load_month < 4'd3) ? 13'd1 : 13'd0);
  assign in_prod = 26'(in_y) * 26'(ccd_pkg::YearRecip);
  assign in_idx = (cmd.load_month >= 4'd1 && cmd.load_month <= 4'd12)
                ? cmd.load_month - 4'd1 : 4'd0;

  // Stage 1 registers
  ccd_pkg::load_t s1_load;
  logic [12:0]    s1_y;
  logic [5:0]     s1_c;
  logic [2:0]     s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && cmd.valid) begin
      s1_load <= in_load;
      s1_y    <= in_y;
      s1_c    <= 6'(in_prod >> ccd_pkg::YearShift);
      s1_off  <= ccd_pkg::MonthOffset[in_idx];
    end
  end

  // Stage 2: weekday sum and remainder by 7
  logic [13:0]    wsum;
  ccd_pkg::load_t s2_load;
  logic [2:0]     s2_wday;

  assign wsum = 14'(s1_y) + 14'(s1_y >> 2) - 14'(s1_c) + 14'(s1_c >> 2)
              + 14'(s1_off) + 14'(s1_load.day);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      s2_load <= s1_load;
      s2_wday <= ccd_pkg::mod7(wsum);
    end
  end

  // Stage 3: clock state update, the state doubles as the status payload
  ccd_pkg::clock_t cur;
  ccd_pkg::clock_t cur_next;
  ccd_pkg::clock_t load_base;
  ccd_pkg::clock_t load_dst;
  logic            applied;
  logic            applied_next;
  logic            summer;

  always_comb begin
    load_base = '{
      second: s2_load.second, minute: s2_load.minute, hour: s2_load.hour,
      day: s2_load.day, month: s2_load.month, year: s2_load.year,
      wday: s2_wday, rep: cur.rep
    };
    summer   = ccd_pkg::is_summer(load_base);
    load_dst = summer ? ccd_pkg::add_one_hour(load_base) : load_base;
    unique case (s2_load.command)
      ccd_pkg::CmdTick: begin
        cur_next     = ccd_pkg::tick_second(cur);
        applied_next = 1'b0;
      end
      ccd_pkg::CmdLoad: begin
        cur_next     = load_base;
        applied_next = 1'b0;
      end
      ccd_pkg::CmdLoadDst: begin
        cur_next     = load_dst;
        applied_next = summer;
      end
      default: begin
        cur_next     = cur;
        applied_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= ccd_pkg::ClockReset;
      applied   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv3) begin
        cur       <= cur_next;
        applied   <= applied_next;
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status outputs
  assign status.valid          = out_valid;
  assign status.cur_second     = cur.second;
  assign status.cur_minute     = cur.minute;
  assign status.cur_hour       = cur.hour;
  assign status.cur_day        = cur.day;
  assign status.cur_month      = cur.month;
  assign status.cur_year       = cur.year;
  assign status.cur_weekday    = cur.wday;
  assign status.summer_applied = applied;

endmodule

`default_nettype wire

### rtl/ccd_checker.sv
// Port-level checker for the calendar clock, bound to the top level.
`default_nettype none

module ccd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [41:0] out_data
);

  // Items accepted but not yet delivered
  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 2'd0;
    end else begin
      inflight <= inflight + 2'(in_acc) - 2'(out_acc);
    end
  end

  // Nothing left in the pipe right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("status valid after reset");

  // A stalled status item keeps valid and payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("status item changed while stalled");

  // Every status item comes from an accepted command
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 2'd0)
    else $error("status item without a command");

  // Full pipe with a stalled receiver takes no command
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd3 && !out_ready |-> !in_ready)
    else $error("command accepted into a full pipe");

  // Empty pipe always takes a command
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd0 |-> in_ready)
    else $error("empty pipe not ready");

endmodule

bind calendar_clock_with_dst_top ccd_checker u_ccd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (status.valid),
  .out_ready (status.ready),
  .out_data  ({status.cur_second, status.cur_minute, status.cur_hour,
               status.cur_day, status.cur_month, status.cur_year,
               status.cur_weekday, status.summer_applied})
);

`default_nettype wire

### bench/calendar_clock_with_dst_top_test.sv
// Self-checking testbench for the calendar clock with summer-time switches.
`default_nettype none

module calendar_clock_with_dst_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Command 3 is not decoded by the block and must leave the clock alone
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int RandomItems = 450;
  localparam int HoldCycles = 60;
  localparam int HoldAfter = 120;
  localparam int SakamotoKey [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  typedef struct {
    logic [1:0]  command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } clock_cmd_t;

  typedef struct {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic        summer;
  } clock_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccd_cmd_if    cmd_ch ();
  ccd_status_if status_ch ();

  calendar_clock_with_dst_top dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .status (status_ch)
  );

  always #5 clk = ~clk;

  clock_cmd_t     pending_items [$];
  clock_reading_t expected_readings [$];
  int errors = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int total_items = 0;

  // Shadow copy of the clock and calendar
  logic [5:0]  now_sec = 6'd0;
  logic [5:0]  now_min = 6'd0;
  logic [4:0]  now_hour = 5'd0;
  logic [4:0]  now_day = 5'd1;
  logic [3:0]  now_month = 4'd1;
  logic [11:0] now_year = 12'd2023;
  logic [2:0]  now_wday = 3'd0;
  logic        now_repeat = 1'b0;

  // Hour increment with day, month and year carry
  function automatic void roll_hour();
    int nd;
    int nm;
    if (now_hour >= 5'd23) begin
      now_hour = 5'd0;
      now_wday = (now_wday >= 3'd6) ? 3'd0 : now_wday + 3'd1;
      nd = now_day + 1;
      nm = now_month;
      if (nd >= 32) begin
        nd = 1;
        nm++;
      end
      if (nd == 31 && (nm == 4 || nm == 6 || nm == 9 || nm == 11)) begin
        nd = 1;
        nm++;
      end
      if (nd == 30 && nm == 2) begin
        nd = 1;
        nm++;
      end
      if (nd == 29 && nm == 2 && now_year[1:0] != 2'd0) begin
        nd = 1;
        nm++;
      end
      if (nm >= 13) begin
        nm = 1;
        now_year = now_year + 12'd1;
      end
      now_day = nd[4:0];
      now_month = nm[3:0];
    end else begin
      now_hour = now_hour + 5'd1;
    end
  endfunction

  // Sakamoto weekday, year biased so the sum stays positive
  function automatic logic [2:0] weekday_for(int yr, int mo, int dd);
    int y;
    int c;
    int idx;
    y = yr + 400 - ((mo < 3) ? 1 : 0);
    c = y / 100;
    idx = (mo >= 1 && mo <= 12) ? mo - 1 : 0;
    return 3'((y + y / 4 - c + c / 4 + SakamotoKey[idx] + dd) % 7);
  endfunction

  // Winter-time value falls inside the summer-time period
  function automatic logic summer_due();
    logic last_week;
    logic past_sun;
    logic summer;
    last_week = now_day > 5'd24;
    past_sun = last_week && (int'(now_wday) <= int'(now_day) - 25);
    summer = 1'b0;
    if (now_month == 4'd3 && last_week) begin
      summer = past_sun;
      if (now_wday == 3'd0 && now_hour < 5'd2) summer = 1'b0;
    end else if (now_month >= 4'd4 && now_month <= 4'd10) begin
      summer = 1'b1;
      if (now_month == 4'd10 && last_week) begin
        if (past_sun) summer = 1'b0;
        if (now_wday == 3'd0 && now_hour < 5'd3) summer = 1'b1;
      end
    end
    return summer;
  endfunction

  // One second forward; spring skips 02:xx, autumn repeats 02:xx once
  function automatic void tick_clock();
    if (now_sec < 6'd59) begin
      now_sec = now_sec + 6'd1;
    end else begin
      now_sec = 6'd0;
      if (now_min < 6'd59) begin
        now_min = now_min + 6'd1;
      end else begin
        now_min = 6'd0;
        if (now_day > 5'd24 && now_wday == 3'd0) begin
          if (now_month == 4'd3 && now_hour == 5'd1) begin
            now_hour = 5'd2;
          end else if (now_month == 4'd10 && now_hour == 5'd2) begin
            if (!now_repeat) now_hour = 5'd1;
            now_repeat = ~now_repeat;
          end
        end
        roll_hour();
      end
    end
  endfunction

  // Apply one command to the shadow clock and return the expected reading
  function automatic clock_reading_t apply_command(clock_cmd_t it);
    clock_reading_t r;
    logic applied;
    applied = 1'b0;
    case (it.command) inside
      ccd_pkg::CmdTick: begin
        tick_clock();
      end
      ccd_pkg::CmdLoad, ccd_pkg::CmdLoadDst: begin
        now_year = it.year;
        now_month = it.month;
        now_day = it.day;
        now_hour = it.hour;
        now_min = it.minute;
        now_sec = it.second;
        now_wday = weekday_for(it.year, it.month, it.day);
        if (it.command == ccd_pkg::CmdLoadDst) begin
          applied = summer_due();
          if (applied) roll_hour();
        end
      end
      default: ;
    endcase
    r.second = now_sec;
    r.minute = now_min;
    r.hour = now_hour;
    r.day = now_day;
    r.month = now_month;
    r.year = now_year;
    r.weekday = now_wday;
    r.summer = applied;
    return r;
  endfunction

  task automatic queue_load(logic [1:0] op, int y, int mo, int d, int h, int mi, int s);
    clock_cmd_t it;
    it.command = op;
    it.year = y[11:0];
    it.month = mo[3:0];
    it.day = d[4:0];
    it.hour = h[4:0];
    it.minute = mi[5:0];
    it.second = s[5:0];
    pending_items.push_back(it);
  endtask

  // Ticks carry random load fields, which the block must ignore
  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) begin
      queue_load(ccd_pkg::CmdTick, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: bursts of items separated by random gaps
  int burst_left;
  int gap_left;
  clock_cmd_t drive_item;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        drive_item.command = cmd_ch.command;
        drive_item.year = cmd_ch.load_year;
        drive_item.month = cmd_ch.load_month;
        drive_item.day = cmd_ch.load_day;
        drive_item.hour = cmd_ch.load_hour;
        drive_item.minute = cmd_ch.load_minute;
        drive_item.second = cmd_ch.load_second;
        expected_readings.push_back(apply_command(drive_item));
        accepted_count++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.command <= drive_item.command;
          cmd_ch.load_year <= drive_item.year;
          cmd_ch.load_month <= drive_item.month;
          cmd_ch.load_day <= drive_item.day;
          cmd_ch.load_hour <= drive_item.hour;
          cmd_ch.load_minute <= drive_item.minute;
          cmd_ch.load_second <= drive_item.second;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(10, 20);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern, with one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  logic [5:0] phase_cnt = 6'd0;
  clock_reading_t want;

  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          $error("status item with no command pending");
          errors++;
        end else begin
          want = expected_readings.pop_front();
          check_field("cur_second", want.second, status_ch.cur_second);
          check_field("cur_minute", want.minute, status_ch.cur_minute);
          check_field("cur_hour", want.hour, status_ch.cur_hour);
          check_field("cur_day", want.day, status_ch.cur_day);
          check_field("cur_month", want.month, status_ch.cur_month);
          check_field("cur_year", want.year, status_ch.cur_year);
          check_field("cur_weekday", want.weekday, status_ch.cur_weekday);
          check_field("summer_applied", want.summer, status_ch.summer_applied);
        end
      end
      phase_cnt <= phase_cnt + 6'd1;
      if (phase_cnt == 6'd0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        status_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        status_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: status_ch.ready <= 1'b1;
          1: status_ch.ready <= ($urandom_range(0, 3) != 0);
          default: status_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int y, mo, d, h, mi, s, dim;
    logic [1:0] op;

    cmd_ch.valid = 1'b0;
    cmd_ch.command = ccd_pkg::CmdTick;
    cmd_ch.load_year = '0;
    cmd_ch.load_month = '0;
    cmd_ch.load_day = '0;
    cmd_ch.load_hour = '0;
    cmd_ch.load_minute = '0;
    cmd_ch.load_second = '0;
    status_ch.ready = 1'b0;

    // Directed: reset state, unused command, field extremes
    queue_ticks(1);
    queue_load(CmdUnused, 4095, 15, 31, 31, 63, 63);
    queue_load(ccd_pkg::CmdLoad, 4095, 15, 31, 31, 63, 63);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoadDst, 0, 0, 0, 0, 0, 0);
    // Year end, leap and common February, 30-day month
    queue_load(ccd_pkg::CmdLoad, 2099, 12, 31, 23, 59, 59);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoad, 2024, 2, 28, 23, 59, 59);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoad, 2023, 2, 28, 23, 59, 59);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoad, 2000, 4, 30, 23, 59, 59);
    queue_ticks(1);
    // Spring skip, then the autumn hour repeated once and then passed
    queue_load(ccd_pkg::CmdLoad, 2024, 3, 31, 1, 59, 59);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoad, 2024, 10, 27, 2, 59, 59);
    queue_ticks(1);
    queue_load(ccd_pkg::CmdLoad, 2024, 10, 27, 2, 59, 59);
    queue_ticks(1);
    // Summer correction on and off around both switch days
    queue_load(ccd_pkg::CmdLoadDst, 2024, 7, 15, 12, 0, 0);
    queue_load(ccd_pkg::CmdLoadDst, 2024, 3, 31, 1, 30, 0);
    queue_load(ccd_pkg::CmdLoadDst, 2024, 3, 31, 2, 30, 0);
    queue_load(ccd_pkg::CmdLoadDst, 2024, 10, 27, 2, 30, 0);
    queue_load(ccd_pkg::CmdLoadDst, 2024, 10, 27, 3, 30, 0);
    queue_load(ccd_pkg::CmdLoadDst, 2024, 6, 30, 23, 30, 0);

    // Random: mostly loads near switch points followed by ticks
    total_items = pending_items.size() + RandomItems;
    while (pending_items.size() < total_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          y = $urandom_range(2000, 2099);
          case ($urandom_range(0, 5))
            0, 1: mo = 3;
            2, 3: mo = 10;
            4: mo = ($urandom_range(0, 1) != 0) ? 2 : 12;
            default: mo = $urandom_range(1, 12);
          endcase
          if (mo == 2) dim = (y % 4 == 0) ? 29 : 28;
          else if (mo == 4 || mo == 6 || mo == 9 || mo == 11) dim = 30;
          else dim = 31;
          d = ($urandom_range(0, 3) != 0) ? $urandom_range(dim - 6, dim)
                                          : $urandom_range(1, dim);
          case ($urandom_range(0, 4))
            0: h = 1;
            1: h = 2;
            2: h = 23;
            3: h = $urandom_range(0, 3);
            default: h = $urandom_range(0, 23);
          endcase
          mi = ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59);
          s = ($urandom_range(0, 3) != 0) ? $urandom_range(55, 59) : $urandom_range(0, 59);
          op = ($urandom_range(0, 1) != 0) ? ccd_pkg::CmdLoad : ccd_pkg::CmdLoadDst;
          queue_load(op, y, mo, d, h, mi, s);
          queue_ticks($urandom_range(1, 8));
        end
        7: begin
          op = ($urandom_range(0, 1) != 0) ? ccd_pkg::CmdLoad : ccd_pkg::CmdLoadDst;
          queue_load(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        8: queue_load(CmdUnused, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: queue_ticks($urandom_range(1, 12));
      endcase
    end
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("** calendar_clock_with_dst_top: PASSED **");
    end else begin
      $display("** calendar_clock_with_dst_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** calendar_clock_with_dst_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
